// ----- rtl/kwm_pkg.sv -----
// Shared types, constants and control structs for the k-way merge min-heap.
package kwm_pkg;

  // Heap capacity and list limits
  localparam int MAX_LISTS    = 16;
  localparam int MAX_LIST_LEN = 8388607;

  // Field widths
  localparam int VALUE_W = 32;
  localparam int LIST_W  = 4;
  localparam int ELEM_W  = 23;
  localparam int ADDR_W  = $clog2(MAX_LISTS);
  localparam int CNT_W   = $clog2(MAX_LISTS + 1);

  // Result status codes
  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  typedef enum logic [1:0] {
    KIND_APPEND   = 2'd0,
    KIND_BUILD    = 2'd1,
    KIND_ADVANCE  = 2'd2,
    KIND_RESERVED = 2'd3
  } kind_t;

  // Input item
  typedef struct packed {
    kind_t                      kind;
    logic signed [VALUE_W-1:0]  value;
    logic [LIST_W-1:0]          list_index;
    logic [ELEM_W-1:0]          list_length;
  } in_t;

  // Result item
  typedef struct packed {
    logic signed [VALUE_W-1:0]  top_value;
    logic [LIST_W-1:0]          top_list;
    logic [ELEM_W-1:0]          top_element;
    logic                       has_more;
    logic [CNT_W-1:0]           heap_size;
    logic                       status;
  } res_t;

  // One heap node
  typedef struct packed {
    logic signed [VALUE_W-1:0]  value;
    logic [LIST_W-1:0]          list;
    logic [ELEM_W-1:0]          element;
  } node_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_ADV_LEN,
    S_ADV_SEL,
    S_BLD_READ,
    S_BLD_LOAD,
    S_SIFT_RD,
    S_SIFT_CMP,
    S_SIFT_END,
    S_ROOT_RD,
    S_ROOT_LEN,
    S_RESULT
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic take_item;
    logic set_reject;
    logic do_append;
    logic bld_init;
    logic adv_read;
    logic len_read;
    logic adv_select;
    logic bld_read;
    logic bld_load;
    logic sift_read;
    logic sift_write_cur;
    logic sift_step;
    logic idx_dec;
    logic root_read;
    logic out_load;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    kind_t kind;
    logic  append_ok;
    logic  count_zero;
    logic  count_ge2;
    logic  child_in;
    logic  best_is_cur;
    logic  idx_zero;
    logic  out_free;
  } sts_t;

endpackage

// ----- rtl/k_way_merge_min_heap.sv -----
// Top level of the k-way merge min-heap: controller plus datapath.
//
// Use: a binary min-heap of list heads for merging up to 16 sorted lists.
// Input channel item_valid/item_ready/item carries one item of kind append,
// build, advance or reserved. Output channel result_valid/result_ready/result
// returns exactly one result per item: the root after the item, whether its
// list holds more elements, the node count and an accept/reject status.
// Items are handled one at a time. An append, a rejected item or a build of
// fewer than two nodes goes straight on to reading the root for the result.
// An advance replaces the root and sifts it down until it stops, at a leaf
// or above one; a build sifts each of the count/2 inner nodes down in turn.
// The node memory has registered reads: each sift level reads both children
// together, then compares and writes back in the next cycle.
// The result sits in an output register; the next item is accepted while it
// waits. If the receiver stalls, the block finishes its current item and
// then holds in its result state until the register frees up.
// Reset (rst, synchronous) empties the heap and drops any pending result;
// node and list-length memories are not cleared and need no clearing pass.
module k_way_merge_min_heap (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  output logic          item_ready,
  input  kwm_pkg::in_t  item,
  output logic          result_valid,
  input  logic          result_ready,
  output kwm_pkg::res_t result
);

  kwm_pkg::cmd_t cmd;
  kwm_pkg::sts_t sts;

  // Sequencer
  kwm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // Heap storage and compare
  kwm_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

// ----- rtl/kwm_ctrl.sv -----
// Sequencer for append, build and advance items, driving the heap datapath.
module kwm_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  output logic          item_ready,
  input  kwm_pkg::sts_t sts,
  output kwm_pkg::cmd_t cmd
);

  kwm_pkg::state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kwm_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    item_ready = 1'b0;
    unique case (state)
      kwm_pkg::S_IDLE: begin
        item_ready    = 1'b1;
        cmd.take_item = item_valid;
        if (item_valid) begin
          state_next = kwm_pkg::S_DECODE;
        end
      end
      kwm_pkg::S_DECODE: begin
        unique case (sts.kind)
          kwm_pkg::KIND_APPEND: begin
            cmd.do_append  = sts.append_ok;
            cmd.set_reject = !sts.append_ok;
            state_next     = kwm_pkg::S_ROOT_RD;
          end
          kwm_pkg::KIND_BUILD: begin
            if (sts.count_ge2) begin
              cmd.bld_init = 1'b1;
              state_next   = kwm_pkg::S_BLD_READ;
            end else begin
              state_next = kwm_pkg::S_ROOT_RD;
            end
          end
          kwm_pkg::KIND_ADVANCE: begin
            if (sts.count_zero) begin
              cmd.set_reject = 1'b1;
              state_next     = kwm_pkg::S_ROOT_RD;
            end else begin
              cmd.adv_read = 1'b1;
              state_next   = kwm_pkg::S_ADV_LEN;
            end
          end
          kwm_pkg::KIND_RESERVED: begin
            cmd.set_reject = 1'b1;
            state_next     = kwm_pkg::S_ROOT_RD;
          end
          default: begin
            cmd.set_reject = 1'b1;
            state_next     = kwm_pkg::S_ROOT_RD;
          end
        endcase
      end
      kwm_pkg::S_ADV_LEN: begin
        cmd.len_read = 1'b1;
        state_next   = kwm_pkg::S_ADV_SEL;
      end
      kwm_pkg::S_ADV_SEL: begin
        cmd.adv_select = 1'b1;
        state_next     = kwm_pkg::S_SIFT_RD;
      end
      kwm_pkg::S_BLD_READ: begin
        cmd.bld_read = 1'b1;
        state_next   = kwm_pkg::S_BLD_LOAD;
      end
      kwm_pkg::S_BLD_LOAD: begin
        cmd.bld_load = 1'b1;
        state_next   = kwm_pkg::S_SIFT_RD;
      end
      kwm_pkg::S_SIFT_RD: begin
        if (sts.child_in) begin
          cmd.sift_read = 1'b1;
          state_next    = kwm_pkg::S_SIFT_CMP;
        end else begin
          cmd.sift_write_cur = 1'b1;
          state_next         = kwm_pkg::S_SIFT_END;
        end
      end
      kwm_pkg::S_SIFT_CMP: begin
        if (sts.best_is_cur) begin
          cmd.sift_write_cur = 1'b1;
          state_next         = kwm_pkg::S_SIFT_END;
        end else begin
          cmd.sift_step = 1'b1;
          state_next    = kwm_pkg::S_SIFT_RD;
        end
      end
      kwm_pkg::S_SIFT_END: begin
        if (sts.kind == kwm_pkg::KIND_BUILD && !sts.idx_zero) begin
          cmd.idx_dec = 1'b1;
          state_next  = kwm_pkg::S_BLD_READ;
        end else begin
          state_next = kwm_pkg::S_ROOT_RD;
        end
      end
      kwm_pkg::S_ROOT_RD: begin
        cmd.root_read = 1'b1;
        state_next    = kwm_pkg::S_ROOT_LEN;
      end
      kwm_pkg::S_ROOT_LEN: begin
        cmd.len_read = 1'b1;
        state_next   = kwm_pkg::S_RESULT;
      end
      kwm_pkg::S_RESULT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = kwm_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = kwm_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/kwm_dp.sv -----
// Heap datapath: node and length memories, sift registers and result register.
module kwm_dp (
  input  logic          clk,
  input  logic          rst,
  input  kwm_pkg::cmd_t cmd,
  output kwm_pkg::sts_t sts,
  input  kwm_pkg::in_t  item,
  output logic          result_valid,
  input  logic          result_ready,
  output kwm_pkg::res_t result
);

  // Node memory, two read ports, one write port
  kwm_pkg::node_t node_mem [kwm_pkg::MAX_LISTS];
  // List length memory, one read port, one write port
  logic [kwm_pkg::ELEM_W-1:0] len_mem [kwm_pkg::MAX_LISTS];

  kwm_pkg::in_t               itm;
  logic                       rej;
  logic [kwm_pkg::CNT_W-1:0]  count;
  logic [kwm_pkg::ADDR_W-1:0] at;
  logic [kwm_pkg::ADDR_W-1:0] idx;
  kwm_pkg::node_t             cur;
  kwm_pkg::node_t             qa;
  kwm_pkg::node_t             qb;
  logic [kwm_pkg::ELEM_W-1:0] ql;

  logic [kwm_pkg::ADDR_W:0]   l_pos;
  logic [kwm_pkg::ADDR_W+1:0] r_pos;
  logic                       r_in;
  logic                       l_lt;
  logic                       r_lt;
  kwm_pkg::node_t             lbest;
  kwm_pkg::node_t             best_node;
  logic [kwm_pkg::ADDR_W-1:0] best_at;
  logic [kwm_pkg::ELEM_W-1:0] len_sat;
  logic                       has_more;

  logic                       rd_a_en;
  logic [kwm_pkg::ADDR_W-1:0] rd_a_addr;
  logic                       rd_b_en;
  logic [kwm_pkg::ADDR_W-1:0] rd_b_addr;
  logic                       wr_en;
  logic [kwm_pkg::ADDR_W-1:0] wr_addr;
  kwm_pkg::node_t             wr_data;

  // Child positions and the smallest of parent and children (parent wins ties, then left child)
  always_comb begin
    l_pos     = {at, 1'b1};
    r_pos     = {1'b0, at, 1'b0} + (kwm_pkg::ADDR_W+2)'(2);
    r_in      = r_pos < {1'b0, count};
    l_lt      = qa.value < cur.value;
    lbest     = l_lt ? qa : cur;
    r_lt      = r_in && (qb.value < lbest.value);
    best_node = r_lt ? qb : qa;
    best_at   = r_lt ? r_pos[kwm_pkg::ADDR_W-1:0] : l_pos[kwm_pkg::ADDR_W-1:0];
  end

  // Appended length, saturated to the list limit
  always_comb begin
    if (itm.list_length > kwm_pkg::ELEM_W'(kwm_pkg::MAX_LIST_LEN)) begin
      len_sat = kwm_pkg::ELEM_W'(kwm_pkg::MAX_LIST_LEN);
    end else begin
      len_sat = itm.list_length;
    end
  end

  // Root list holds another element: qa is the root, ql its list length
  assign has_more = ({1'b0, qa.element} + (kwm_pkg::ELEM_W+1)'(1)) < {1'b0, ql};

  // Status to controller
  always_comb begin
    sts.kind        = itm.kind;
    sts.append_ok   = ({1'b0, itm.list_index} < (kwm_pkg::LIST_W+1)'(kwm_pkg::MAX_LISTS))
                      && ((len_sat == '0)
                          || (count < kwm_pkg::CNT_W'(kwm_pkg::MAX_LISTS)));
    sts.count_zero  = (count == '0);
    sts.count_ge2   = (count >= kwm_pkg::CNT_W'(2));
    sts.child_in    = l_pos < count;
    sts.best_is_cur = !l_lt && !r_lt;
    sts.idx_zero    = (idx == '0);
    sts.out_free    = !result_valid || result_ready;
  end

  // Node memory port selection
  always_comb begin
    rd_a_en   = cmd.adv_read || cmd.root_read || cmd.bld_read || cmd.sift_read;
    rd_a_addr = '0;
    if (cmd.bld_read) begin
      rd_a_addr = idx;
    end else if (cmd.sift_read) begin
      rd_a_addr = l_pos[kwm_pkg::ADDR_W-1:0];
    end
    rd_b_en   = cmd.adv_read || cmd.sift_read;
    rd_b_addr = r_pos[kwm_pkg::ADDR_W-1:0];
    if (cmd.adv_read) begin
      rd_b_addr = kwm_pkg::ADDR_W'(count - kwm_pkg::CNT_W'(1));
    end
    wr_en   = 1'b0;
    wr_addr = at;
    wr_data = cur;
    if (cmd.do_append && len_sat != '0) begin
      wr_en           = 1'b1;
      wr_addr         = count[kwm_pkg::ADDR_W-1:0];
      wr_data.value   = itm.value;
      wr_data.list    = itm.list_index;
      wr_data.element = '0;
    end else if (cmd.sift_write_cur) begin
      wr_en = 1'b1;
    end else if (cmd.sift_step) begin
      wr_en   = 1'b1;
      wr_data = best_node;
    end
  end

  // Memories with registered read data
  always_ff @(posedge clk) begin
    if (wr_en) begin
      node_mem[wr_addr] <= wr_data;
    end
    if (cmd.do_append) begin
      len_mem[itm.list_index] <= len_sat;
    end
    if (rd_a_en) begin
      qa <= node_mem[rd_a_addr];
    end
    if (rd_b_en) begin
      qb <= node_mem[rd_b_addr];
    end
    if (cmd.len_read) begin
      ql <= len_mem[qa.list];
    end
  end

  // Item, sift and build registers
  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      itm <= item;
    end
    if (cmd.bld_init) begin
      idx <= count[kwm_pkg::ADDR_W:1] - kwm_pkg::ADDR_W'(1);
    end else if (cmd.idx_dec) begin
      idx <= idx - kwm_pkg::ADDR_W'(1);
    end
    if (cmd.adv_select) begin
      at <= '0;
      if (has_more) begin
        cur.value   <= itm.value;
        cur.list    <= qa.list;
        cur.element <= qa.element + kwm_pkg::ELEM_W'(1);
      end else begin
        cur <= qb;
      end
    end else if (cmd.bld_load) begin
      at  <= idx;
      cur <= qa;
    end else if (cmd.sift_step) begin
      at <= best_at;
    end
  end

  // Control registers: node count and reject flag
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      rej   <= kwm_pkg::STATUS_OK;
    end else begin
      if (cmd.take_item) begin
        rej <= kwm_pkg::STATUS_OK;
      end else if (cmd.set_reject) begin
        rej <= kwm_pkg::STATUS_REJECT;
      end
      if (cmd.do_append && len_sat != '0) begin
        count <= count + kwm_pkg::CNT_W'(1);
      end else if (cmd.adv_select && !has_more) begin
        count <= count - kwm_pkg::CNT_W'(1);
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.out_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (count != '0) begin
        result.top_value   <= qa.value;
        result.top_list    <= qa.list;
        result.top_element <= qa.element;
        result.has_more    <= has_more;
      end else begin
        result.top_value   <= '0;
        result.top_list    <= '0;
        result.top_element <= '0;
        result.has_more    <= 1'b0;
      end
      result.heap_size <= count;
      result.status    <= rej;
    end
  end

endmodule

// ----- rtl/kwm_checker.sv -----
// Port-level assertions for the k-way merge min-heap, bound to the top level.
module kwm_checker (
  input logic          clk,
  input logic          rst,
  input logic          item_valid,
  input logic          item_ready,
  input kwm_pkg::in_t  item,
  input logic          result_valid,
  input logic          result_ready,
  input kwm_pkg::res_t result
);

  // A stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // Heap never exceeds its capacity
  a_size_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.heap_size <= kwm_pkg::CNT_W'(kwm_pkg::MAX_LISTS))
    else $error("heap size above capacity");

  // An empty heap reports a cleared root
  a_empty_root: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.heap_size == '0 |->
      result.top_value == '0 && result.top_list == '0 &&
      result.top_element == '0 && !result.has_more)
    else $error("empty heap with nonzero root");

  // One item at a time: no acceptance in the cycle after an accepted item
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("item taken while busy");

  // Reset drops any pending result
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind k_way_merge_min_heap kwm_checker u_kwm_checker (.*);
